// ----- design/pgsb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and fixed-point helpers for the particle step pipeline.
package pgsb_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_GRAVITY     = 3'd0;
   localparam logic [2:0] CSR_STEP_LEN    = 3'd1;
   localparam logic [2:0] CSR_BOUNDARY    = 3'd2;
   localparam logic [2:0] CSR_RADIUS      = 3'd3;
   localparam logic [2:0] CSR_RESTITUTION = 3'd4;

   // register reset values
   localparam logic signed [23:0] GRAVITY_RST     = -24'sd642253;
   localparam logic [15:0]        STEP_LEN_RST    = 16'd1092;
   localparam logic [29:0]        BOUNDARY_RST    = 30'd327680;
   localparam logic [29:0]        RADIUS_RST      = 30'd6554;
   localparam logic [16:0]        RESTITUTION_RST = 17'd52429;

   // saturation limits of a Q16.16 word, at the width of the wide sums
   localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
   localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

   // one half LSB of Q16.16 at 32 fraction bits
   localparam logic signed [51:0] HALF_LSB = 52'sd32768;

   typedef struct packed {
      logic signed [23:0] gravity;
      logic [15:0]        step_len;
      logic [29:0]        boundary;
      logic [29:0]        radius;
      logic [16:0]        restitution;
   } pgsb_cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               held;
   } pgsb_req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
   } pgsb_rsp_type;

   // hand-off from the integration stages to the wall stages
   typedef struct packed {
      pgsb_req_type       orig;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_y;
      logic signed [49:0] disp_y;
      logic signed [31:0] bnc_x1;
      logic signed [31:0] bnc_z1;
      logic signed [49:0] prod_x2;
      logic signed [49:0] prod_z2;
      logic signed [49:0] prod_y;
   } pgsb_kin_type;

   // clamp a wide signed sum to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      if (x > SAT_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (x < SAT_MIN) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // 32 fraction bits to 16, rounded half up
   function automatic logic signed [35:0] round16(input logic signed [51:0] x);
      logic signed [51:0] s;
      s = x + HALF_LSB;
      return $signed(s[51:16]);
   endfunction

   // finish a bounce from the product v*restitution: negate, round, saturate
   function automatic logic signed [31:0] bounce_fin(input logic signed [49:0] prod);
      logic signed [51:0] neg;
      neg = -52'(prod);
      return sat32(40'(round16(neg)));
   endfunction

endpackage

// ----- design/pgsb_kin.sv -----
`timescale 1ns / 1ps
// Integration stages: products, rounding and new positions and velocities before walls.
module pgsb_kin import pgsb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pgsb_cfg_type cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  pgsb_req_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output pgsb_kin_type out_data
);

   logic signed [16:0] dt_s;
   logic signed [17:0] rest_s;

   logic en1, en2, en3;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;

   // stage 1
   pgsb_req_type       s1_orig_ff;
   logic signed [48:0] s1_mx_in, s1_mx_ff;
   logic signed [48:0] s1_my_in, s1_my_ff;
   logic signed [48:0] s1_mz_in, s1_mz_ff;
   logic signed [40:0] s1_gdt_in, s1_gdt_ff;
   logic signed [49:0] s1_bxp_in, s1_bxp_ff;
   logic signed [49:0] s1_bzp_in, s1_bzp_ff;

   // stage 2
   pgsb_req_type       s2_orig_ff;
   logic signed [35:0] s2_dxr_in, s2_dxr_ff;
   logic signed [35:0] s2_dzr_in, s2_dzr_ff;
   logic signed [48:0] s2_my_ff;
   logic signed [56:0] s2_ggt_in, s2_ggt_ff;
   logic signed [31:0] s2_vy_in, s2_vy_ff;
   logic signed [31:0] s2_bx1_in, s2_bx1_ff;
   logic signed [31:0] s2_bz1_in, s2_bz1_ff;

   // stage 3
   pgsb_req_type       s3_orig_ff;
   logic signed [31:0] s3_px_in, s3_px_ff;
   logic signed [31:0] s3_pz_in, s3_pz_ff;
   logic signed [49:0] s3_dy_in, s3_dy_ff;
   logic signed [31:0] s3_vy_ff;
   logic signed [31:0] s3_bx1_ff;
   logic signed [31:0] s3_bz1_ff;
   logic signed [49:0] s3_bx2p_in, s3_bx2p_ff;
   logic signed [49:0] s3_bz2p_in, s3_bz2p_ff;
   logic signed [49:0] s3_byp_in, s3_byp_ff;

   assign dt_s   = $signed({1'b0, cfg.step_len});
   assign rest_s = $signed({1'b0, cfg.restitution});

   // per-stage advance: a stage loads when empty or when the next one moves
   assign en3      = !s3_vld_ff || out_ready;
   assign en2      = !s2_vld_ff || en3;
   assign en1      = !s1_vld_ff || en2;
   assign in_ready = en1;

   // stage 1: velocity and gravity products, first bounce products
   always_comb begin
      s1_mx_in  = 49'(in_data.vel_x) * 49'(dt_s);
      s1_my_in  = 49'(in_data.vel_y) * 49'(dt_s);
      s1_mz_in  = 49'(in_data.vel_z) * 49'(dt_s);
      s1_gdt_in = 41'(cfg.gravity) * 41'(dt_s);
      s1_bxp_in = 50'(in_data.vel_x) * 50'(rest_s);
      s1_bzp_in = 50'(in_data.vel_z) * 50'(rest_s);
   end

   // stage 2: g*dt*dt, rounding, new vy, first bounces
   always_comb begin
      s2_dxr_in = round16(52'(s1_mx_ff));
      s2_dzr_in = round16(52'(s1_mz_ff));
      s2_ggt_in = 57'(s1_gdt_ff) * 57'(dt_s);
      s2_vy_in  = sat32(40'(s1_orig_ff.vel_y) + 40'(round16(52'(s1_gdt_ff))));
      s2_bx1_in = bounce_fin(s1_bxp_ff);
      s2_bz1_in = bounce_fin(s1_bzp_ff);
   end

   // stage 3: new x and z, y displacement, second bounce products for x and z, y bounce product
   always_comb begin
      s3_px_in   = sat32(40'(s2_orig_ff.pos_x) + 40'(s2_dxr_ff));
      s3_pz_in   = sat32(40'(s2_orig_ff.pos_z) + 40'(s2_dzr_ff));
      s3_dy_in   = 50'(s2_my_ff) + 50'(s2_ggt_ff >>> 17);
      s3_bx2p_in = 50'(s2_bx1_ff) * 50'(rest_s);
      s3_bz2p_in = 50'(s2_bz1_ff) * 50'(rest_s);
      s3_byp_in  = 50'(s2_vy_ff) * 50'(rest_s);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_vld_ff <= in_valid;
         end
         if (en2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (en3) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_orig_ff <= in_data;
         s1_mx_ff   <= s1_mx_in;
         s1_my_ff   <= s1_my_in;
         s1_mz_ff   <= s1_mz_in;
         s1_gdt_ff  <= s1_gdt_in;
         s1_bxp_ff  <= s1_bxp_in;
         s1_bzp_ff  <= s1_bzp_in;
      end
      if (en2) begin
         s2_orig_ff <= s1_orig_ff;
         s2_dxr_ff  <= s2_dxr_in;
         s2_dzr_ff  <= s2_dzr_in;
         s2_my_ff   <= s1_my_ff;
         s2_ggt_ff  <= s2_ggt_in;
         s2_vy_ff   <= s2_vy_in;
         s2_bx1_ff  <= s2_bx1_in;
         s2_bz1_ff  <= s2_bz1_in;
      end
      if (en3) begin
         s3_orig_ff <= s2_orig_ff;
         s3_px_ff   <= s3_px_in;
         s3_pz_ff   <= s3_pz_in;
         s3_dy_ff   <= s3_dy_in;
         s3_vy_ff   <= s2_vy_ff;
         s3_bx1_ff  <= s2_bx1_ff;
         s3_bz1_ff  <= s2_bz1_ff;
         s3_bx2p_ff <= s3_bx2p_in;
         s3_bz2p_ff <= s3_bz2p_in;
         s3_byp_ff  <= s3_byp_in;
      end
   end

   assign out_valid = s3_vld_ff;

   always_comb begin
      out_data.orig    = s3_orig_ff;
      out_data.pos_x   = s3_px_ff;
      out_data.pos_z   = s3_pz_ff;
      out_data.vel_y   = s3_vy_ff;
      out_data.disp_y  = s3_dy_ff;
      out_data.bnc_x1  = s3_bx1_ff;
      out_data.bnc_z1  = s3_bz1_ff;
      out_data.prod_x2 = s3_bx2p_ff;
      out_data.prod_z2 = s3_bz2p_ff;
      out_data.prod_y  = s3_byp_ff;
   end

endmodule

// ----- design/pgsb_wall.sv -----
`timescale 1ns / 1ps
// Wall stages: new y, wall checks, clamping, bounce select and the output register.
module pgsb_wall import pgsb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pgsb_cfg_type cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  pgsb_kin_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output pgsb_rsp_type out_data
);

   // p - r < -b, at full precision
   function automatic logic below_lo(input logic signed [31:0] p, input logic [29:0] r,
                                     input logic [29:0] b);
      logic signed [33:0] t;
      t = 34'(p) - $signed({4'b0, r}) + $signed({4'b0, b});
      return t[33];
   endfunction

   // p + r > b, at full precision
   function automatic logic above_hi(input logic signed [31:0] p, input logic [29:0] r,
                                     input logic [29:0] b);
      logic signed [33:0] t;
      t = 34'(p) + $signed({4'b0, r}) - $signed({4'b0, b});
      return !t[33] && (t != '0);
   endfunction

   logic en4, en5, en6;
   logic s4_vld_ff, s5_vld_ff, s6_vld_ff;

   logic               r_gt_b;
   logic signed [31:0] clamp_lo;
   logic signed [31:0] clamp_hi;

   // stage 4
   pgsb_req_type       s4_orig_ff;
   logic signed [31:0] s4_px_ff, s4_pz_ff, s4_vy_ff;
   logic signed [31:0] s4_bx1_ff, s4_bz1_ff;
   logic signed [31:0] s4_bx2_in, s4_bx2_ff;
   logic signed [31:0] s4_bz2_in, s4_bz2_ff;
   logic signed [31:0] s4_by1_in, s4_by1_ff;
   logic signed [35:0] s4_dyr_in, s4_dyr_ff;
   logic s4_xlo_in, s4_xlo_ff, s4_xhi_in, s4_xhi_ff;
   logic s4_zlo_in, s4_zlo_ff, s4_zhi_in, s4_zhi_ff;

   // stage 5
   pgsb_req_type       s5_orig_ff;
   logic signed [31:0] s5_x_in, s5_x_ff;
   logic signed [31:0] s5_z_in, s5_z_ff;
   logic signed [31:0] s5_vx_in, s5_vx_ff;
   logic signed [31:0] s5_vz_in, s5_vz_ff;
   logic signed [31:0] s5_py_in, s5_py_ff;
   logic signed [31:0] s5_vy_ff, s5_by1_ff;

   // stage 6 (output register)
   pgsb_rsp_type s6_rsp_in, s6_rsp_ff;

   assign en6      = !s6_vld_ff || out_ready;
   assign en5      = !s5_vld_ff || en6;
   assign en4      = !s4_vld_ff || en5;
   assign in_ready = en4;

   // clamp targets; config is to change only while idle, which the block itself does not enforce
   assign r_gt_b   = cfg.radius > cfg.boundary;
   assign clamp_lo = $signed({2'b0, cfg.radius}) - $signed({2'b0, cfg.boundary});
   assign clamp_hi = $signed({2'b0, cfg.boundary}) - $signed({2'b0, cfg.radius});

   // stage 4: finish bounces, round y displacement, x and z wall tests
   always_comb begin
      s4_bx2_in = bounce_fin(in_data.prod_x2);
      s4_bz2_in = bounce_fin(in_data.prod_z2);
      s4_by1_in = bounce_fin(in_data.prod_y);
      s4_dyr_in = round16(52'(in_data.disp_y));
      s4_xlo_in = below_lo(in_data.pos_x, cfg.radius, cfg.boundary);
      s4_xhi_in = above_hi(in_data.pos_x, cfg.radius, cfg.boundary);
      s4_zlo_in = below_lo(in_data.pos_z, cfg.radius, cfg.boundary);
      s4_zhi_in = above_hi(in_data.pos_z, cfg.radius, cfg.boundary);
   end

   // stage 5: new y, resolve x and z walls (low hit with r > b lands on the high wall too)
   always_comb begin
      s5_py_in = sat32(40'(s4_orig_ff.pos_y) + 40'(s4_dyr_ff));

      if (s4_xlo_ff) begin
         s5_x_in  = r_gt_b ? clamp_hi : clamp_lo;
         s5_vx_in = r_gt_b ? s4_bx2_ff : s4_bx1_ff;
      end else if (s4_xhi_ff) begin
         s5_x_in  = clamp_hi;
         s5_vx_in = s4_bx1_ff;
      end else begin
         s5_x_in  = s4_px_ff;
         s5_vx_in = s4_orig_ff.vel_x;
      end

      if (s4_zlo_ff) begin
         s5_z_in  = r_gt_b ? clamp_hi : clamp_lo;
         s5_vz_in = r_gt_b ? s4_bz2_ff : s4_bz1_ff;
      end else if (s4_zhi_ff) begin
         s5_z_in  = clamp_hi;
         s5_vz_in = s4_bz1_ff;
      end else begin
         s5_z_in  = s4_pz_ff;
         s5_vz_in = s4_orig_ff.vel_z;
      end
   end

   // stage 6: floor check, held pass-through
   always_comb begin
      s6_rsp_in.new_pos_x = s5_x_ff;
      s6_rsp_in.new_pos_z = s5_z_ff;
      s6_rsp_in.new_vel_x = s5_vx_ff;
      s6_rsp_in.new_vel_z = s5_vz_ff;
      if (below_lo(s5_py_ff, cfg.radius, cfg.boundary)) begin
         s6_rsp_in.new_pos_y = clamp_lo;
         s6_rsp_in.new_vel_y = s5_by1_ff;
      end else begin
         s6_rsp_in.new_pos_y = s5_py_ff;
         s6_rsp_in.new_vel_y = s5_vy_ff;
      end
      if (s5_orig_ff.held) begin
         s6_rsp_in.new_pos_x = s5_orig_ff.pos_x;
         s6_rsp_in.new_pos_y = s5_orig_ff.pos_y;
         s6_rsp_in.new_pos_z = s5_orig_ff.pos_z;
         s6_rsp_in.new_vel_x = s5_orig_ff.vel_x;
         s6_rsp_in.new_vel_y = s5_orig_ff.vel_y;
         s6_rsp_in.new_vel_z = s5_orig_ff.vel_z;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         if (en4) begin
            s4_vld_ff <= in_valid;
         end
         if (en5) begin
            s5_vld_ff <= s4_vld_ff;
         end
         if (en6) begin
            s6_vld_ff <= s5_vld_ff;
         end
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en4) begin
         s4_orig_ff <= in_data.orig;
         s4_px_ff   <= in_data.pos_x;
         s4_pz_ff   <= in_data.pos_z;
         s4_vy_ff   <= in_data.vel_y;
         s4_bx1_ff  <= in_data.bnc_x1;
         s4_bz1_ff  <= in_data.bnc_z1;
         s4_bx2_ff  <= s4_bx2_in;
         s4_bz2_ff  <= s4_bz2_in;
         s4_by1_ff  <= s4_by1_in;
         s4_dyr_ff  <= s4_dyr_in;
         s4_xlo_ff  <= s4_xlo_in;
         s4_xhi_ff  <= s4_xhi_in;
         s4_zlo_ff  <= s4_zlo_in;
         s4_zhi_ff  <= s4_zhi_in;
      end
      if (en5) begin
         s5_orig_ff <= s4_orig_ff;
         s5_x_ff    <= s5_x_in;
         s5_z_ff    <= s5_z_in;
         s5_vx_ff   <= s5_vx_in;
         s5_vz_ff   <= s5_vz_in;
         s5_py_ff   <= s5_py_in;
         s5_vy_ff   <= s4_vy_ff;
         s5_by1_ff  <= s4_by1_ff;
      end
      if (en6) begin
         s6_rsp_ff  <= s6_rsp_in;
      end
   end

   assign out_valid = s6_vld_ff;
   assign out_data  = s6_rsp_ff;

endmodule

// ----- design/particle_gravity_step_wall_bounce.sv -----
`timescale 1ns / 1ps
// Pipeline: six register stages, three integration stages and then three wall stages ending in the output register.
// Throughput: one particle per cycle while rsp_ready holds, set by the six-stage multiply/round/clamp pipeline.
// Each stage loads when empty or when the one after it moves, so bubbles close up under stall.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// Top level: configuration registers, integration stages and wall stages.
module particle_gravity_step_wall_bounce import pgsb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  pgsb_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pgsb_rsp_type rsp_payload,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [29:0]  csr_wdata
);

   pgsb_cfg_type cfg_ff;
   logic         kin_valid;
   logic         kin_ready;
   pgsb_kin_type kin_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity     <= GRAVITY_RST;
         cfg_ff.step_len    <= STEP_LEN_RST;
         cfg_ff.boundary    <= BOUNDARY_RST;
         cfg_ff.radius      <= RADIUS_RST;
         cfg_ff.restitution <= RESTITUTION_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRAVITY:     cfg_ff.gravity     <= $signed(csr_wdata[23:0]);
            CSR_STEP_LEN:    cfg_ff.step_len    <= csr_wdata[15:0];
            CSR_BOUNDARY:    cfg_ff.boundary    <= csr_wdata;
            CSR_RADIUS:      cfg_ff.radius      <= csr_wdata;
            CSR_RESTITUTION: cfg_ff.restitution <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // integration stages
   pgsb_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (kin_valid),
      .out_ready (kin_ready),
      .out_data  (kin_data)
   );

   // wall stages and output register
   pgsb_wall u_wall (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (kin_valid),
      .in_ready  (kin_ready),
      .in_data   (kin_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

endmodule
